@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked assertion, also checked while reset is applied
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

// clocked assertion, off while reset is applied
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

`endif

@@ sv/vbib_pkg.sv @@
// ----------------------------------------------------------------------------
// vbib_pkg
// shared constants, action codes and controller/datapath types for the
// voxel box id binning unit
// ----------------------------------------------------------------------------
package vbib_pkg;

    // default geometry
    localparam int GRID_DIM_DEF     = 16;
    localparam int MAX_PER_CELL_DEF = 4;
    localparam int MAX_HALF_DEF     = 7;
    localparam int ID_WIDTH_DEF     = 16;

    // port field widths
    localparam int ACT_W     = 2;
    localparam int POS_W     = 4;
    localparam int HALF_W    = 3;
    localparam int OBJ_W     = 16;
    localparam int COLOR_W   = 32;
    localparam int OUT_CNT_W = 12;

    // signed walk coordinate, covers position minus / plus a half extent
    localparam int C_W = 6;

    // action codes
    localparam logic [ACT_W-1:0] ACT_SOLID  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PLACE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    typedef struct packed {
        logic load;      // capture input word, start walk
        logic clr;       // clearing pass step
        logic solid;     // set solid voxel write
        logic rd;        // read cell at walk position
        logic upd;       // modify and write back cell, advance walk
        logic out_load;  // move counters into output register
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;  // clearing pass at last cell
        logic walk_last; // walk at last box offset
    } t_dp_stat;

endpackage

@@ sv/vbib_ctrl.sv @@
// ----------------------------------------------------------------------------
// vbib_ctrl
// sequencer for clearing pass, set solid and box walk, plus output valid
// ----------------------------------------------------------------------------
module vbib_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [vbib_pkg::ACT_W-1:0]      i_action,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output vbib_pkg::t_dp_cmd               o_cmd,
    input  vbib_pkg::t_dp_stat              i_stat
);
    import vbib_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SOLID  = 3'd2;
    localparam logic [2:0] S_VISIT  = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       acc;
    logic       out_free;

    assign acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    o_cmd.load = 1'b1;
                    case (i_action)
                        ACT_SOLID:  n_state = S_SOLID;
                        ACT_PLACE:  n_state = S_VISIT;
                        ACT_REMOVE: n_state = S_VISIT;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_SOLID: begin
                o_cmd.solid = 1'b1;
                n_state     = S_DONE;
            end
            S_VISIT: begin
                o_cmd.rd = 1'b1;
                n_state  = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.upd = 1'b1;
                n_state   = i_stat.walk_last ? S_DONE : S_VISIT;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ sv/vbib_datapath.sv @@
// ----------------------------------------------------------------------------
// vbib_datapath
// cell memories, box walk coordinates, per cell read-modify-write and
// result counters
// ----------------------------------------------------------------------------
module vbib_datapath #(
    parameter int GRID_DIM     = vbib_pkg::GRID_DIM_DEF,
    parameter int MAX_PER_CELL = vbib_pkg::MAX_PER_CELL_DEF,
    parameter int MAX_HALF     = vbib_pkg::MAX_HALF_DEF,
    parameter int ID_WIDTH     = vbib_pkg::ID_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  vbib_pkg::t_dp_cmd               i_cmd,
    output vbib_pkg::t_dp_stat              o_stat,
    input  logic [vbib_pkg::ACT_W-1:0]      i_action,
    input  logic [vbib_pkg::POS_W-1:0]      i_pos_x,
    input  logic [vbib_pkg::POS_W-1:0]      i_pos_y,
    input  logic [vbib_pkg::POS_W-1:0]      i_pos_z,
    input  logic [vbib_pkg::HALF_W-1:0]     i_half_x,
    input  logic [vbib_pkg::HALF_W-1:0]     i_half_y,
    input  logic [vbib_pkg::HALF_W-1:0]     i_half_z,
    input  logic [vbib_pkg::OBJ_W-1:0]      i_object_id,
    input  logic [vbib_pkg::COLOR_W-1:0]    i_color,
    output logic [vbib_pkg::OUT_CNT_W-1:0]  o_cells_changed,
    output logic [vbib_pkg::OUT_CNT_W-1:0]  o_cells_at_limit,
    output logic                            o_upload_request
);
    import vbib_pkg::*;

    localparam int NCELLS = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam int IDX_W  = $clog2(NCELLS);
    localparam int CNT_W  = $clog2(MAX_PER_CELL + 1);
    localparam int SL_W   = (MAX_PER_CELL > 1) ? $clog2(MAX_PER_CELL) : 1;
    localparam int LI_W   = $clog2(32 * (1 + GRID_DIM + GRID_DIM * GRID_DIM)) + 2;
    localparam int HC_W   = HALF_W + 1;

    localparam logic signed [LI_W-1:0] G_S  = LI_W'(GRID_DIM);
    localparam logic signed [LI_W-1:0] G2_S = LI_W'(GRID_DIM * GRID_DIM);
    localparam logic signed [LI_W-1:0] NC_S = LI_W'(NCELLS);
    localparam logic [HC_W-1:0]        MAX_HALF_C = HC_W'(MAX_HALF);
    localparam logic [CNT_W-1:0]       MAX_CNT    = CNT_W'(MAX_PER_CELL);
    localparam logic [IDX_W-1:0]       LAST_IDX   = IDX_W'(NCELLS - 1);

    typedef logic [MAX_PER_CELL-1:0][ID_WIDTH-1:0] t_row;

    // cell stores
    logic               mem_solid [NCELLS];
    logic [CNT_W-1:0]   mem_count [NCELLS];
    t_row               mem_ids   [NCELLS];
    logic [COLOR_W-1:0] mem_color [NCELLS];

    logic                     r_rd_solid;
    logic [CNT_W-1:0]         r_rd_count;
    t_row                     r_rd_row;

    logic [IDX_W-1:0]         r_clr;
    logic [ACT_W-1:0]         r_act;
    logic [ID_WIDTH-1:0]      r_id;
    logic [COLOR_W-1:0]       r_color;
    logic signed [C_W-1:0]    r_x, r_y, r_z;
    logic signed [C_W-1:0]    r_xe, r_ye, r_ze;
    logic signed [C_W-1:0]    r_y0, r_z0;
    logic [IDX_W-1:0]         r_li;
    logic                     r_inr;
    logic [OUT_CNT_W-1:0]     r_changed, r_at_limit;
    logic                     r_upload;
    logic [OUT_CNT_W-1:0]     r_out_changed, r_out_at_limit;
    logic                     r_out_upload;

    logic [HC_W-1:0]          hx_c, hy_c, hz_c;
    logic signed [C_W-1:0]    px_s, py_s, pz_s, hx_s, hy_s, hz_s;
    logic                     off_en;
    logic signed [LI_W-1:0]   li;
    logic [IDX_W-1:0]         li_idx;
    logic                     li_inr;

    logic                     cell_ok;
    logic                     is_place;
    logic                     full;
    logic                     hit;
    logic [SL_W-1:0]          hit_k;
    logic [ID_WIDTH-1:0]      last_id;
    t_row                     new_row;
    logic [CNT_W-1:0]         new_count;
    logic                     wr_row;
    logic                     lim_inc;

    // half extent saturation
    always_comb begin
        hx_c = ({1'b0, i_half_x} > MAX_HALF_C) ? MAX_HALF_C : {1'b0, i_half_x};
        hy_c = ({1'b0, i_half_y} > MAX_HALF_C) ? MAX_HALF_C : {1'b0, i_half_y};
        hz_c = ({1'b0, i_half_z} > MAX_HALF_C) ? MAX_HALF_C : {1'b0, i_half_z};
    end

    // set solid uses the walk registers with a zero offset
    assign off_en = (i_action != ACT_SOLID);
    assign px_s   = C_W'(i_pos_x);
    assign py_s   = C_W'(i_pos_y);
    assign pz_s   = C_W'(i_pos_z);
    assign hx_s   = off_en ? C_W'(hx_c) : '0;
    assign hy_s   = off_en ? C_W'(hy_c) : '0;
    assign hz_s   = off_en ? C_W'(hz_c) : '0;

    // linear index, range checked as a whole only
    assign li     = LI_W'(r_x) + LI_W'(r_y) * G_S + LI_W'(r_z) * G2_S;
    assign li_idx = li[IDX_W-1:0];
    assign li_inr = (li >= 0) && (li < NC_S);

    assign o_stat.clr_last  = (r_clr == LAST_IDX);
    assign o_stat.walk_last = (r_x == r_xe) && (r_y == r_ye) && (r_z == r_ze);

    // cell update
    assign cell_ok  = r_inr && !r_rd_solid;
    assign is_place = (r_act == ACT_PLACE);
    assign full     = (r_rd_count >= MAX_CNT);

    always_comb begin
        hit     = 1'b0;
        hit_k   = '0;
        last_id = r_rd_row[0];
        for (int k = 0; k < MAX_PER_CELL; k++) begin
            if (!hit && (CNT_W'(k) < r_rd_count) && (r_rd_row[k] == r_id)) begin
                hit   = 1'b1;
                hit_k = SL_W'(k);
            end
            if (CNT_W'(k + 1) == r_rd_count) begin
                last_id = r_rd_row[k];
            end
        end
    end

    always_comb begin
        new_row = r_rd_row;
        for (int k = 0; k < MAX_PER_CELL; k++) begin
            if (is_place) begin
                if (CNT_W'(k) == r_rd_count) begin
                    new_row[k] = r_id;
                end
            end else if (SL_W'(k) == hit_k) begin
                // first match takes the last entry
                new_row[k] = last_id;
            end
        end
        new_count = is_place ? (r_rd_count + 1'b1) : (r_rd_count - 1'b1);
    end

    assign wr_row  = i_cmd.upd && cell_ok && (is_place ? !full : hit);
    assign lim_inc = i_cmd.upd && cell_ok && is_place && full;

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem_solid[r_clr] <= 1'b0;
        end else if (i_cmd.solid && li_inr) begin
            mem_solid[li_idx] <= 1'b1;
        end
        r_rd_solid <= mem_solid[li_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem_count[r_clr] <= '0;
        end else if (wr_row) begin
            mem_count[r_li] <= new_count;
        end
        r_rd_count <= mem_count[li_idx];
    end

    always_ff @(posedge i_clk) begin
        if (wr_row) begin
            mem_ids[r_li] <= new_row;
        end
        r_rd_row <= mem_ids[li_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.solid && li_inr) begin
            mem_color[li_idx] <= r_color;
        end
    end

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // item capture and walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= i_action;
            r_id    <= ID_WIDTH'(i_object_id);
            r_color <= i_color;
            r_x     <= px_s - hx_s;
            r_y     <= py_s - hy_s;
            r_z     <= pz_s - hz_s;
            r_y0    <= py_s - hy_s;
            r_z0    <= pz_s - hz_s;
            r_xe    <= px_s + hx_s;
            r_ye    <= py_s + hy_s;
            r_ze    <= pz_s + hz_s;
        end else if (i_cmd.upd) begin
            // z innermost, x outermost
            if (r_z != r_ze) begin
                r_z <= r_z + 1'b1;
            end else begin
                r_z <= r_z0;
                if (r_y != r_ye) begin
                    r_y <= r_y + 1'b1;
                end else begin
                    r_y <= r_y0;
                    r_x <= r_x + 1'b1;
                end
            end
        end
        if (i_cmd.rd) begin
            r_li  <= li_idx;
            r_inr <= li_inr;
        end
    end

    // result counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_changed  <= '0;
            r_at_limit <= '0;
            r_upload   <= 1'b0;
        end else if (i_cmd.solid) begin
            r_changed <= li_inr ? OUT_CNT_W'(1) : '0;
            r_upload  <= li_inr;
        end else begin
            if (wr_row) begin
                r_changed <= r_changed + 1'b1;
            end
            if (lim_inc) begin
                r_at_limit <= r_at_limit + 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_out_changed  <= r_changed;
            r_out_at_limit <= r_at_limit;
            r_out_upload   <= r_upload;
        end
    end

    assign o_cells_changed  = r_out_changed;
    assign o_cells_at_limit = r_out_at_limit;
    assign o_upload_request = r_out_upload;

endmodule

@@ sv/voxel_box_id_binning_unit.sv @@
// ----------------------------------------------------------------------------
// voxel_box_id_binning_unit
// uniform voxel grid with solid flag, color and short id list per cell;
// set solid, place id over box, remove id over box
// ----------------------------------------------------------------------------
// sequence: set solid goes from load to the solid write, then done; an unused action
//   goes from load straight to done; place or remove walks (2hx+1)*(2hy+1)*(2hz+1) cells, then done
// throughput: one word at a time; the walk does one read-modify-write of the
//   cell memories per box cell (read, then update)
// reset: a clearing pass over all GRID_DIM^3 cells (4096 by default) zeroes the
//   solid flags and id counts; no input word is taken until it is done
module voxel_box_id_binning_unit #(
    parameter int GRID_DIM     = vbib_pkg::GRID_DIM_DEF,
    parameter int MAX_PER_CELL = vbib_pkg::MAX_PER_CELL_DEF,
    parameter int MAX_HALF     = vbib_pkg::MAX_HALF_DEF,
    parameter int ID_WIDTH     = vbib_pkg::ID_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [vbib_pkg::ACT_W-1:0]      i_action,
    input  logic [vbib_pkg::POS_W-1:0]      i_pos_x,
    input  logic [vbib_pkg::POS_W-1:0]      i_pos_y,
    input  logic [vbib_pkg::POS_W-1:0]      i_pos_z,
    input  logic [vbib_pkg::HALF_W-1:0]     i_half_x,
    input  logic [vbib_pkg::HALF_W-1:0]     i_half_y,
    input  logic [vbib_pkg::HALF_W-1:0]     i_half_z,
    input  logic [vbib_pkg::OBJ_W-1:0]      i_object_id,
    input  logic [vbib_pkg::COLOR_W-1:0]    i_color,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [vbib_pkg::OUT_CNT_W-1:0]  o_cells_changed,
    output logic [vbib_pkg::OUT_CNT_W-1:0]  o_cells_at_limit,
    output logic                            o_upload_request
);
    import vbib_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    vbib_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    vbib_datapath #(
        .GRID_DIM     (GRID_DIM),
        .MAX_PER_CELL (MAX_PER_CELL),
        .MAX_HALF     (MAX_HALF),
        .ID_WIDTH     (ID_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_action         (i_action),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_half_x         (i_half_x),
        .i_half_y         (i_half_y),
        .i_half_z         (i_half_z),
        .i_object_id      (i_object_id),
        .i_color          (i_color),
        .o_cells_changed  (o_cells_changed),
        .o_cells_at_limit (o_cells_at_limit),
        .o_upload_request (o_upload_request)
    );

endmodule

@@ sv/vbib_checker.sv @@
// ----------------------------------------------------------------------------
// vbib_checker
// port level checks for the voxel box id binning unit, bound to the top
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vbib_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_stall,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic [vbib_pkg::OUT_CNT_W-1:0]  o_cells_changed,
    input  logic [vbib_pkg::OUT_CNT_W-1:0]  o_cells_at_limit,
    input  logic                            o_upload_request
);
    import vbib_pkg::*;

    // reset clears output valid and holds off input until the clear is done
    `ASSERT_CLK(a_rst_out_idle, i_clk, !i_rst_n |=> !o_out_valid)
    `ASSERT_CLK(a_rst_in_stall, i_clk, !i_rst_n |=> o_in_stall)

    // one word in flight: an accepted word blocks the input next cycle
    `ASSERT_CLK_RST(a_acc_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall)

    // a solid write touches exactly one cell and never hits a full list
    `ASSERT_CLK_RST(a_upload_one, i_clk, i_rst_n, o_out_valid && o_upload_request |-> o_cells_changed == 1 && o_cells_at_limit == 0)

    // stalled output word stays valid
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid)

endmodule

bind voxel_box_id_binning_unit vbib_checker u_vbib_checker (.*);
